// File: rtl/sfr_pkg.sv
// types and constants shared by the serial frame receiver
// depends on nothing
`default_nettype none

package sfr_pkg;

   typedef enum logic [1:0] {
      CMD_RECV  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_ACK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_HEAD = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2,
      PH_END  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_ACCEPT = 2'd1,
      ST_DONE   = 2'd2,
      ST_REJECT = 2'd3
   } status_type;

   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_P    = 8'h50;
   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_E    = 8'h45;
   localparam logic [7:0] CHAR_N    = 8'h4e;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_0    = 8'h30;
   localparam logic [7:0] CHAR_9    = 8'h39;

   localparam int HDR_BYTES = 5;
   localparam int LEN_END   = 9;
   localparam int MIN_FRAME = 12;
   localparam int DECL_W    = 14;

endpackage

`default_nettype wire

// File: rtl/sfr_req_if.sv
// request channel of the serial frame receiver: valid/ready plus the command beat
// depends on nothing
`default_nettype none

interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] rx_byte;
   logic [7:0] read_index;

   modport source (output valid, output cmd, output rx_byte, output read_index,
                   input ready);
   modport sink   (input valid, input cmd, input rx_byte, input read_index,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/sfr_rsp_if.sv
// response channel of the serial frame receiver: valid/ready plus the result beat
// depends on nothing
`default_nettype none

interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       frame_ready;
   logic [7:0] frame_length;
   logic [7:0] read_data;

   modport source (output valid, output status, output frame_ready,
                   output frame_length, output read_data, input ready);
   modport sink   (input valid, input status, input frame_ready,
                   input frame_length, input read_data, output ready);
endinterface

`default_nettype wire

// File: rtl/sfr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
`default_nettype none

module sfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/serial_frame_receiver_core.sv
// Serial frame receiver. Each request beat carries one command (receive a byte, clear the
// receiver, read a stored frame byte, acknowledge ready) and produces exactly one response
// beat, in the cycle after it is taken; a new request is taken every cycle while the response
// register is empty or being drained. Frames have the form 'A' 'P' 'S', two version bytes,
// four ASCII length digits, payload, 'E' 'N' 'D'. Bytes go into one ram of two banks of
// 2**CW entries (CW = $clog2(BUF_DEPTH)): incoming bytes fill the receive bank while the other
// bank holds the last complete frame, and completing a frame just swaps the banks, so no
// frame is copied. Frame read data comes from the registered ram read port. Ram contents need
// no clearing after reset; a stored byte is only returned below the stored frame length.
// depends on sfr_pkg, sfr_req_if, sfr_rsp_if, sfr_ram
`default_nettype none

module serial_frame_receiver_core
   import sfr_pkg::*;
#(
   parameter int BUF_DEPTH = 256
) (
   input wire logic  clock,
   input wire logic  reset,
   sfr_req_if.sink   req_chan,
   sfr_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(BUF_DEPTH);
   localparam int IW = (CW > 8) ? CW : 8;

   // control state
   phase_type          phase_ff, phase_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [DECL_W-1:0]  decl_ff, decl_in;
   logic [CW-1:0]      stored_ff, stored_in;
   logic               ready_flag_ff, ready_flag_in;
   logic               bank_ff, bank_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // response payload
   status_type         status_ff, status_in;
   logic               hit_ff, hit_in;

   logic               accept;
   logic               drop;
   logic               is_digit;
   logic [CW-1:0]      count_inc;
   logic [DECL_W-1:0]  pos_w;
   logic [DECL_W-1:0]  len_cand;
   logic               wr_en;
   logic               rd_en;
   logic [7:0]         ram_q;
   cmd_type            cmd;

   assign cmd       = cmd_type'(req_chan.cmd);
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept    = req_chan.valid && req_chan.ready;
   assign is_digit  = (req_chan.rx_byte >= CHAR_0) && (req_chan.rx_byte <= CHAR_9);
   assign count_inc = count_ff + CW'(1);
   assign pos_w     = DECL_W'(count_ff);
   // decimal accumulate: decl * 10 + digit
   assign len_cand  = (decl_ff << 3) + (decl_ff << 1) + DECL_W'(req_chan.rx_byte[3:0]);
   assign rd_en     = accept && (cmd == CMD_READ);

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      decl_in       = decl_ff;
      stored_in     = stored_ff;
      ready_flag_in = ready_flag_ff;
      bank_in       = bank_ff;
      status_in     = ST_IDLE;
      hit_in        = 1'b0;
      wr_en         = 1'b0;
      drop          = 1'b0;
      if (accept) begin
         unique case (cmd)
            CMD_RECV: begin
               wr_en = 1'b1;
               status_in = ST_ACCEPT;
               unique case (phase_ff)
                  PH_HEAD: begin
                     if (count_ff == '0 && req_chan.rx_byte != CHAR_A) begin
                        // noise between frames
                        status_in = ST_IDLE;
                     end else if ((count_ff == CW'(1) && req_chan.rx_byte != CHAR_P) ||
                                  (count_ff == CW'(2) && req_chan.rx_byte != CHAR_S)) begin
                        drop = 1'b1;
                     end else begin
                        count_in = count_inc;
                        if (count_inc == CW'(HDR_BYTES)) begin
                           phase_in = PH_LEN;
                        end
                     end
                  end
                  PH_LEN: begin
                     if (!is_digit) begin
                        drop = 1'b1;
                     end else begin
                        count_in = count_inc;
                        decl_in  = len_cand;
                        if (count_inc == CW'(LEN_END)) begin
                           if (len_cand < DECL_W'(MIN_FRAME) ||
                               len_cand >= DECL_W'(BUF_DEPTH)) begin
                              drop = 1'b1;
                           end else if (len_cand == DECL_W'(MIN_FRAME)) begin
                              phase_in = PH_END;
                           end else begin
                              phase_in = PH_DATA;
                           end
                        end
                     end
                  end
                  PH_DATA: begin
                     count_in = count_inc;
                     if (DECL_W'(count_inc) == decl_ff - DECL_W'(3)) begin
                        phase_in = PH_END;
                     end
                  end
                  PH_END: begin
                     if (pos_w == decl_ff - DECL_W'(3)) begin
                        drop     = (req_chan.rx_byte != CHAR_E);
                        count_in = count_inc;
                     end else if (pos_w == decl_ff - DECL_W'(2)) begin
                        drop     = (req_chan.rx_byte != CHAR_N);
                        count_in = count_inc;
                     end else if (req_chan.rx_byte != CHAR_D) begin
                        drop = 1'b1;
                     end else begin
                        // frame done: receive bank becomes the readable bank
                        status_in     = ST_DONE;
                        stored_in     = CW'(decl_ff);
                        ready_flag_in = 1'b1;
                        bank_in       = !bank_ff;
                        phase_in      = PH_HEAD;
                        count_in      = '0;
                        decl_in       = '0;
                     end
                  end
                  default: begin
                     phase_in = PH_HEAD;
                  end
               endcase
            end
            CMD_CLEAR: begin
               phase_in = PH_HEAD;
               count_in = '0;
               decl_in  = '0;
            end
            CMD_READ: begin
               hit_in = IW'(req_chan.read_index) < IW'(stored_ff);
            end
            CMD_ACK: begin
               ready_flag_in = 1'b0;
            end
            default: begin
               status_in = ST_IDLE;
            end
         endcase
         if (drop) begin
            status_in = ST_REJECT;
            phase_in  = PH_HEAD;
            count_in  = '0;
            decl_in   = '0;
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEAD;
         count_ff      <= '0;
         decl_ff       <= '0;
         stored_ff     <= '0;
         ready_flag_ff <= 1'b0;
         bank_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         decl_ff       <= decl_in;
         stored_ff     <= stored_in;
         ready_flag_ff <= ready_flag_in;
         bank_ff       <= bank_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // response beat payload, loaded with each request beat
   logic           frame_ready_ff;
   logic [CW-1:0]  length_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         hit_ff         <= hit_in;
         frame_ready_ff <= ready_flag_in;
         length_ff      <= stored_in;
      end
   end

   // each bank spans the full count range so the bank bit can sit above the count
   sfr_ram #(
      .WIDTH (8),
      .DEPTH (2 * (1 << CW))
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({!bank_ff, count_ff}),
      .wr_data (req_chan.rx_byte),
      .rd_en   (rd_en),
      .rd_addr ({bank_ff, CW'(req_chan.read_index)}),
      .rd_data (ram_q)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.frame_ready  = frame_ready_ff;
   assign rsp_chan.frame_length = 8'(length_ff);
   assign rsp_chan.read_data    = hit_ff ? ram_q : 8'd0;

   a_done_sets_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_DONE |-> frame_ready_ff)
      else $error("completed frame without ready flag");

   a_ack_clears_ready: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == CMD_ACK |=> !ready_flag_ff && !frame_ready_ff)
      else $error("acknowledge did not clear ready flag");

   a_len_phase_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LEN |-> count_ff >= CW'(HDR_BYTES) && count_ff < CW'(LEN_END))
      else $error("length digits counted out of range");

   a_trailer_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_END |-> decl_ff >= DECL_W'(MIN_FRAME) &&
                             decl_ff < DECL_W'(BUF_DEPTH))
      else $error("trailer reached with invalid declared length");

endmodule

`default_nettype wire

// File: tb/sfr_frame_checker.sv
// response checker for the serial frame receiver: tracks the frame parser state from the
// request beats it sees and compares every response beat against its own prediction
// depends on sfr_pkg, sfr_req_if, sfr_rsp_if
`default_nettype none

module sfr_frame_checker
   import sfr_pkg::*;
#(
   parameter int BUF_DEPTH = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   sfr_req_if        req_chan,
   sfr_rsp_if        rsp_chan,
   output int        error_count,
   output int        pending,
   output int        frames_taken,
   output int        frames_dropped
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type status;
      logic       frame_ready;
      logic [7:0] frame_length;
      logic [7:0] read_data;
   } rsp_beat_type;

   // parser state, kept apart from the block
   phase_type  rx_phase;
   int         rx_pos;
   int         decl_len;
   logic [7:0] rx_buf[BUF_DEPTH];
   logic [7:0] held_frame[BUF_DEPTH];
   int         held_len;
   logic       held_flag;

   rsp_beat_type awaited_rsp[$];
   int         errs;
   int         taken;
   int         dropped;

   function automatic status_type drop_partial();
      rx_phase = PH_HEAD;
      rx_pos   = 0;
      decl_len = 0;
      return ST_REJECT;
   endfunction

   function automatic status_type take_rx(input logic [7:0] b);
      int pos;
      int len;
      int k;
      pos = rx_pos;
      if (pos >= BUF_DEPTH) return drop_partial();
      rx_buf[pos] = b;
      case (rx_phase)
         PH_HEAD: begin
            if (pos == 0 && b != CHAR_A) begin
               rx_pos = 0;
               return ST_IDLE;
            end
            if ((pos == 1 && b != CHAR_P) || (pos == 2 && b != CHAR_S))
               return drop_partial();
            rx_pos = pos + 1;
            if (rx_pos == HDR_BYTES) rx_phase = PH_LEN;
            return ST_ACCEPT;
         end
         PH_LEN: begin
            if (b < CHAR_0 || b > CHAR_9) return drop_partial();
            rx_pos = pos + 1;
            if (rx_pos == LEN_END) begin
               len = (int'(rx_buf[5]) - int'(CHAR_0)) * 1000 +
                     (int'(rx_buf[6]) - int'(CHAR_0)) * 100 +
                     (int'(rx_buf[7]) - int'(CHAR_0)) * 10 +
                     (int'(rx_buf[8]) - int'(CHAR_0));
               decl_len = len;
               if (len < MIN_FRAME || len >= BUF_DEPTH) return drop_partial();
               rx_phase = (rx_pos == len - 3) ? PH_END : PH_DATA;
            end
            return ST_ACCEPT;
         end
         PH_DATA: begin
            rx_pos = pos + 1;
            if (rx_pos == decl_len - 3) rx_phase = PH_END;
            return ST_ACCEPT;
         end
         default: begin
            if (pos == decl_len - 3) begin
               if (b != CHAR_E) return drop_partial();
            end else if (pos == decl_len - 2) begin
               if (b != CHAR_N) return drop_partial();
            end else begin
               if (b != CHAR_D) return drop_partial();
               for (k = 0; k < decl_len; k++) held_frame[k] = rx_buf[k];
               held_len  = decl_len;
               held_flag = 1'b1;
               rx_phase  = PH_HEAD;
               rx_pos    = 0;
               decl_len  = 0;
               return ST_DONE;
            end
            rx_pos = pos + 1;
            return ST_ACCEPT;
         end
      endcase
   endfunction

   function automatic rsp_beat_type parse_beat(input cmd_type cmd, input logic [7:0] b,
                                               input logic [7:0] idx);
      rsp_beat_type r;
      r.status    = ST_IDLE;
      r.read_data = 8'h00;
      case (cmd)
         CMD_RECV: r.status = take_rx(b);
         CMD_CLEAR: begin
            rx_phase = PH_HEAD;
            rx_pos   = 0;
            decl_len = 0;
         end
         CMD_READ: begin
            if (idx < held_len) r.read_data = held_frame[idx];
         end
         default: held_flag = 1'b0;
      endcase
      r.frame_ready  = held_flag;
      r.frame_length = held_len[7:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         rx_phase  = PH_HEAD;
         rx_pos    = 0;
         decl_len  = 0;
         held_len  = 0;
         held_flag = 1'b0;
         awaited_rsp.delete();
      end else begin
         // the response of a beat shows up at a later edge, so retire before predicting
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("response beat with no request waiting for it");
               errs++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  errs++;
               end
               if (rsp_chan.frame_ready !== want.frame_ready) begin
                  $error("frame_ready: expected %0d, got %0d", want.frame_ready,
                         rsp_chan.frame_ready);
                  errs++;
               end
               if (rsp_chan.frame_length !== want.frame_length) begin
                  $error("frame_length: expected %0d, got %0d", want.frame_length,
                         rsp_chan.frame_length);
                  errs++;
               end
               if (rsp_chan.read_data !== want.read_data) begin
                  $error("read_data: expected 0x%02h, got 0x%02h", want.read_data,
                         rsp_chan.read_data);
                  errs++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            want = parse_beat(cmd_type'(req_chan.cmd), req_chan.rx_byte, req_chan.read_index);
            if (want.status == ST_DONE) taken++;
            if (want.status == ST_REJECT) dropped++;
            awaited_rsp.push_back(want);
         end
      end
      error_count    <= errs;
      pending        <= awaited_rsp.size();
      frames_taken   <= taken;
      frames_dropped <= dropped;
   end

endmodule

`default_nettype wire

// File: tb/tb.sv
// top of the serial frame receiver testbench: clock, reset, request and response
// traffic, and the verdict; depends on sfr_pkg, both channel interfaces,
// serial_frame_receiver_core and sfr_frame_checker
`default_nettype none

module tb
   import sfr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF_DEPTH   = 256;
   localparam int ITEM_TARGET = 1750;
   localparam int CALM_FROM   = 1500;
   localparam int DRAIN_EVERY = 350;
   localparam int QUIET_LIMIT = 1000;

   typedef enum int {
      FLAW_NONE,
      FLAW_HEADER,
      FLAW_DIGIT,
      FLAW_SHORT,
      FLAW_LONG,
      FLAW_TRAILER,
      FLAW_CUT
   } flaw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;

   int   fails;
   int   pending;
   int   frames_taken;
   int   frames_dropped;
   int   items;
   int   last_len;
   int   stall_left;
   int   quiet;

   sfr_req_if req_chan ();
   sfr_rsp_if rsp_chan ();

   serial_frame_receiver_core #(.BUF_DEPTH(BUF_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sfr_frame_checker #(.BUF_DEPTH(BUF_DEPTH)) frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .error_count    (fails),
      .pending        (pending),
      .frames_taken   (frames_taken),
      .frames_dropped (frames_dropped)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response side backpressure in bursts
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left     <= stall_left - 1;
         rsp_chan.ready <= (stall_left == 1);
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left     <= $urandom_range(1, 8);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_beat(input cmd_type cmd, input logic [7:0] b, input logic [7:0] idx);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= cmd;
      req_chan.rx_byte    <= b;
      req_chan.read_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      items++;
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic send_frame(input int len, input flaw_type flaw);
      int         i;
      int         k;
      int         cut;
      int         declared;
      logic [7:0] nd;
      logic [7:0] frame_bytes[$];
      declared = len;
      if (flaw == FLAW_SHORT)
         declared = ($urandom_range(0, 3) == 0) ? MIN_FRAME - 1 : $urandom_range(0, MIN_FRAME - 1);
      if (flaw == FLAW_LONG)
         declared = ($urandom_range(0, 3) == 0) ? BUF_DEPTH : $urandom_range(BUF_DEPTH, 9999);
      frame_bytes = {CHAR_A, CHAR_P, CHAR_S, 8'($urandom), 8'($urandom)};
      frame_bytes.push_back(8'(CHAR_0 + (declared / 1000) % 10));
      frame_bytes.push_back(8'(CHAR_0 + (declared / 100) % 10));
      frame_bytes.push_back(8'(CHAR_0 + (declared / 10) % 10));
      frame_bytes.push_back(8'(CHAR_0 + declared % 10));
      for (k = LEN_END; k < len - 3; k++) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(CHAR_E);
      frame_bytes.push_back(CHAR_N);
      frame_bytes.push_back(CHAR_D);
      cut = frame_bytes.size();
      case (flaw)
         FLAW_HEADER: begin
            i = $urandom_range(1, 2);
            frame_bytes[i] = frame_bytes[i] ^ 8'($urandom_range(1, 255));
            cut = i + 1;
         end
         FLAW_DIGIT: begin
            i = $urandom_range(5, 8);
            if ($urandom_range(0, 3) == 0)
               nd = $urandom_range(0, 1) ? CHAR_0 - 8'd1 : CHAR_9 + 8'd1;
            else
               do nd = 8'($urandom); while (nd >= CHAR_0 && nd <= CHAR_9);
            frame_bytes[i] = nd;
            cut = i + 1;
         end
         FLAW_SHORT, FLAW_LONG: cut = LEN_END;
         FLAW_TRAILER: begin
            i = $urandom_range(len - 3, len - 1);
            frame_bytes[i] = frame_bytes[i] ^ 8'($urandom_range(1, 255));
         end
         FLAW_CUT: cut = $urandom_range(1, len - 1);
         default: last_len = len;
      endcase
      for (k = 0; k < cut; k++) begin
         // reads and acks may land in the middle of a frame without disturbing it
         if ($urandom_range(0, 39) == 0)
            send_beat(cmd_type'($urandom_range(0, 1) ? CMD_READ : CMD_ACK), 8'($urandom),
                      8'($urandom));
         send_beat(CMD_RECV, frame_bytes[k], 8'($urandom));
      end
      if (flaw == FLAW_CUT) send_beat(CMD_CLEAR, 8'($urandom), 8'($urandom));
   endtask

   initial begin
      logic [7:0] shortest[12];
      logic [7:0] idx;
      int         k;
      int         r;
      int         next_drain;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_RECV;
      req_chan.rx_byte    = 8'h00;
      req_chan.read_index = 8'h00;
      shortest = '{CHAR_A, CHAR_P, CHAR_S, 8'h00, 8'hff, CHAR_0, CHAR_0, CHAR_0 + 8'd1,
                   CHAR_0 + 8'd2, CHAR_E, CHAR_N, CHAR_D};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // nothing stored yet, then idle noise at both byte extremes
      send_beat(CMD_READ, 8'h00, 8'h00);
      send_beat(CMD_RECV, 8'h00, 8'hff);
      send_beat(CMD_RECV, 8'hff, 8'h00);
      // header that breaks at the second byte
      send_beat(CMD_RECV, CHAR_A, 8'h00);
      send_beat(CMD_RECV, CHAR_S, 8'h00);
      // shortest legal frame: no payload at all
      for (k = 0; k < 12; k++) send_beat(CMD_RECV, shortest[k], 8'h00);
      send_beat(CMD_READ, 8'h00, 8'd0);
      send_beat(CMD_READ, 8'h00, 8'd11);
      send_beat(CMD_READ, 8'h00, 8'd12);
      send_beat(CMD_READ, 8'hff, 8'hff);
      send_beat(CMD_ACK, 8'h00, 8'h00);
      send_beat(CMD_CLEAR, 8'hff, 8'hff);
      last_len = MIN_FRAME;
      drain_results();

      send_frame(BUF_DEPTH - 1, FLAW_NONE);
      next_drain = items + DRAIN_EVERY;
      while (items < ITEM_TARGET) begin
         if (items >= CALM_FROM && !calm) calm <= 1'b1;
         r = $urandom_range(0, 99);
         if (r < 55) begin
            send_frame(($urandom_range(0, 15) == 0) ? $urandom_range(41, BUF_DEPTH - 1)
                                                     : $urandom_range(MIN_FRAME, 40),
                       FLAW_NONE);
         end else if (r < 75) begin
            send_frame($urandom_range(MIN_FRAME, 40),
                       flaw_type'($urandom_range(FLAW_HEADER, FLAW_CUT)));
         end else if (r < 85) begin
            // line noise between frames
            repeat ($urandom_range(1, 6)) begin
               send_beat(CMD_RECV, 8'($urandom), 8'($urandom));
            end
         end else if (r < 92) begin
            if (last_len > 0 && $urandom_range(0, 1))
               idx = 8'($urandom_range(0, last_len - 1));
            else
               idx = 8'($urandom);
            send_beat(CMD_READ, 8'($urandom), idx);
         end else if (r < 96) begin
            send_beat(CMD_ACK, 8'($urandom), 8'($urandom));
         end else begin
            send_beat(CMD_CLEAR, 8'($urandom), 8'($urandom));
         end
         if (items >= next_drain) begin
            drain_results();
            next_drain = items + DRAIN_EVERY;
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("run covered %0d command beats: %0d frames delivered, %0d frames rejected",
               items, frames_taken, frames_dropped);
      if (fails == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
rtl/sfr_pkg.sv
rtl/sfr_req_if.sv
rtl/sfr_rsp_if.sv
rtl/sfr_ram.sv
rtl/serial_frame_receiver_core.sv
tb/sfr_frame_checker.sv
tb/tb.sv
